[rtl/core/gsg_pkg.sv]
// Shared constants, register codes and table-building functions for the
// two-peak Gaussian model unit. No dependencies.
`timescale 1ns / 1ps

package gsg_pkg;

  localparam int NPEAKS_DEF    = 2;
  localparam int EXP_DEPTH_DEF = 256;
  localparam int MAX_PEAKS     = 2;
  localparam int QUO_BITS      = 32;
  localparam int DIV_LAT       = QUO_BITS + 2;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam longint Q30_ONE   = longint'(1) <<< 30;

  // register index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_AMPLITUDE_FIRST  = 3'd0,
    REG_CENTER_FIRST     = 3'd1,
    REG_WIDTH_FIRST      = 3'd2,
    REG_AMPLITUDE_SECOND = 3'd3,
    REG_CENTER_SECOND    = 3'd4,
    REG_WIDTH_SECOND     = 3'd5
  } cfg_reg_t;

  // exp(-h) in Q2.30 by a Taylor series through the h^16 term, h in Q2.30
  function automatic longint exp_series(input longint h);
    longint term;
    longint r;
    term = Q30_ONE;
    r    = Q30_ONE;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 1;  r = r - term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 2;  r = r + term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 3;  r = r - term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 4;  r = r + term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 5;  r = r - term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 6;  r = r + term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 7;  r = r - term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 8;  r = r + term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 9;  r = r - term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 10; r = r + term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 11; r = r - term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 12; r = r + term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 13; r = r - term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 14; r = r + term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 15; r = r - term;
    term = (term * h + Q30_ONE / 2) / Q30_ONE / 16; r = r + term;
    return r;
  endfunction

  // table entry k: r^k in Q2.30, rounded to Q16.16
  function automatic logic [31:0] exp_rom_entry(input longint r, input int k);
    longint cur;
    int     j;
    cur = Q30_ONE;
    for (j = 0; j < k; j++) begin
      cur = (cur * r + (longint'(1) <<< 29)) >>> 30;
    end
    return 32'((cur + 8192) >>> 14);
  endfunction

endpackage

[rtl/core/gaussian_sum_with_gradient_unit.sv]
// Two-peak Gaussian model with parameter derivatives, Q16.16 in and out.
// Uses gsg_pkg and gsg_div.
`timescale 1ns / 1ps

// One sample x goes in per transaction and one result comes out per
// transaction; a new sample is taken every clock cycle unless the output
// stalls. Samples pass two 34-stage bit-per-stage dividers (argument,
// then derivatives) with 12 stages of exp table lookup, interpolation
// and multiplies between them; a stall on the output freezes the whole
// pipeline. The user must write widths, centers and amplitudes over APB
// only while no sample is in flight; the block itself does not enforce
// it. A zero width raises m_tuser (fault) and zeroes every data field.

module gaussian_sum_with_gradient_unit #(
  parameter int NPEAKS          = gsg_pkg::NPEAKS_DEF,
  parameter int EXP_TABLE_DEPTH = gsg_pkg::EXP_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,   // [31:0] x_value
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [31:0] model_value, [63:32] d_amplitude_first, [95:64] d_center_first,
  // [127:96] d_width_first, [159:128] d_amplitude_second,
  // [191:160] d_center_second, [223:192] d_width_second
  output logic [223:0]                m_tdata,
  output logic [0:0]                  m_tuser,   // [0] fault
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gsg_pkg::ADDR_W-1:0]  paddr,
  input  logic [gsg_pkg::DATA_W-1:0]  pwdata,
  output logic [gsg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int MP   = gsg_pkg::MAX_PEAKS;
  localparam int DL   = gsg_pkg::DIV_LAT;
  localparam int NSTG = 2 * DL + 14;
  localparam int IW   = $clog2(EXP_TABLE_DEPTH + 1);
  localparam longint ROM_STEP =
    ((longint'(16) <<< 30) + EXP_TABLE_DEPTH / 2) / EXP_TABLE_DEPTH;
  localparam longint ROM_RATIO = gsg_pkg::exp_series(ROM_STEP);

  // configuration registers
  logic signed [31:0] amp [MP];
  logic signed [31:0] ctr [MP];
  logic signed [31:0] wid [MP];

  logic               adv;
  logic [NSTG-1:0]    vld;
  logic signed [31:0] x_r;

  logic signed [31:0] dcq   [MP];
  logic signed [31:0] dwq   [MP];
  logic signed [33:0] ae_o  [MP];
  logic [16:0]        e_o   [MP];
  logic               ez_o  [MP];
  logic               wz_o  [MP];

  logic [16:0]        rom [EXP_TABLE_DEPTH+1];

  logic               flt;
  logic signed [34:0] msum;
  logic signed [31:0] model;
  logic [223:0]       out_data;
  logic               out_fault;

  // exp(-16k/DEPTH) table
  for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_rom
    assign rom[k] = 17'(gsg_pkg::exp_rom_entry(ROM_RATIO, k));
  end

  // APB register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp[0] <= '0;
      ctr[0] <= '0;
      wid[0] <= 32'sd65536;
      amp[1] <= '0;
      ctr[1] <= '0;
      wid[1] <= 32'sd65536;
    end else if (psel && penable && pwrite && pready) begin
      case (gsg_pkg::cfg_reg_t'(paddr[4:2]))
        gsg_pkg::REG_AMPLITUDE_FIRST:  amp[0] <= pwdata;
        gsg_pkg::REG_CENTER_FIRST:     ctr[0] <= pwdata;
        gsg_pkg::REG_WIDTH_FIRST:      wid[0] <= pwdata;
        gsg_pkg::REG_AMPLITUDE_SECOND: amp[1] <= pwdata;
        gsg_pkg::REG_CENTER_SECOND:    ctr[1] <= pwdata;
        gsg_pkg::REG_WIDTH_SECOND:     wid[1] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (gsg_pkg::cfg_reg_t'(paddr[4:2]))
      gsg_pkg::REG_AMPLITUDE_FIRST:  prdata = amp[0];
      gsg_pkg::REG_CENTER_FIRST:     prdata = ctr[0];
      gsg_pkg::REG_WIDTH_FIRST:      prdata = wid[0];
      gsg_pkg::REG_AMPLITUDE_SECOND: prdata = amp[1];
      gsg_pkg::REG_CENTER_SECOND:    prdata = ctr[1];
      gsg_pkg::REG_WIDTH_SECOND:     prdata = wid[1];
      default:                       prdata = '0;
    endcase
  end

  // pipeline advance: the whole pipe moves unless the output is held
  assign adv      = ~m_tvalid | m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= s_tdata;
    end
  end

  // per-peak datapath
  for (genvar p = 0; p < MP; p++) begin : g_peak
    if (p < NPEAKS) begin : g_on
      logic signed [32:0] diff;
      logic signed [48:0] anum;
      logic signed [31:0] arg_q;
      logic               wz_a;
      logic [63:0]        pos;

      logic [31:0]        amag1;
      logic signed [18:0] arg1, arg2, arg3, arg4, arg5, arg6, arg7, arg8;
      logic signed [18:0] arg9, arg10, arg11;
      logic               wz1, wz2, wz3, wz4, wz5, wz6, wz7, wz8, wz9, wz10;
      logic               wz11, wz12;
      logic [63:0]        u2;
      logic [IW-1:0]      idx3;
      logic [15:0]        frac3, frac4, frac5;
      logic               zf3, zf4, zf5, zf6;
      logic [16:0]        lo4, hi4, lo5, lo6, dif5;
      logic [32:0]        prod6;
      logic [16:0]        e7, e8, e9, e10, e11, e12;
      logic signed [49:0] pa8;
      logic signed [33:0] ae9, ae10, ae11, ae12;
      logic signed [52:0] g10;
      logic signed [37:0] f11;
      logic signed [56:0] h12;
      logic signed [53:0] nc12;

      // arg = (x - center) * 2^16 / width
      assign diff = $signed({x_r[31], x_r}) - $signed({ctr[p][31], ctr[p]});
      assign anum = {diff, 16'b0};

      gsg_div #(.NW(49), .SW(1)) u_arg (
        .clk      (clk),
        .en       (adv),
        .num      (anum),
        .den      (wid[p]),
        .side_in  (wid[p] == '0),
        .quo      (arg_q),
        .side_out (wz_a)
      );

      // table position from arg^2
      assign pos = ({28'b0, u2[35:0]} * 64'(EXP_TABLE_DEPTH)) >> 4;

      always_ff @(posedge clk) begin
        if (adv) begin
          // |arg|, arg^2
          amag1 <= arg_q[31] ? 32'(-arg_q) : arg_q;
          arg1  <= arg_q[18:0];
          wz1   <= wz_a;
          u2    <= {32'b0, amag1} * {32'b0, amag1};
          arg2  <= arg1;
          wz2   <= wz1;
          // index and fraction; out of table range gives zero
          zf3   <= (|u2[63:36]) || (pos[63:32] >= 32'(EXP_TABLE_DEPTH));
          idx3  <= ((|u2[63:36]) || (pos[63:32] >= 32'(EXP_TABLE_DEPTH))) ?
                   '0 : pos[32 +: IW];
          frac3 <= pos[31:16];
          arg3  <= arg2;
          wz3   <= wz2;
          // table read
          lo4   <= rom[idx3];
          hi4   <= rom[IW'(idx3 + 1'b1)];
          frac4 <= frac3;
          zf4   <= zf3;
          arg4  <= arg3;
          wz4   <= wz3;
          // linear interpolation
          dif5  <= (hi4 > lo4) ? '0 : 17'(lo4 - hi4);
          lo5   <= lo4;
          frac5 <= frac4;
          zf5   <= zf4;
          arg5  <= arg4;
          wz5   <= wz4;
          prod6 <= 33'(dif5) * 33'(frac5);
          lo6   <= lo5;
          zf6   <= zf5;
          arg6  <= arg5;
          wz6   <= wz5;
          e7    <= zf6 ? '0 : 17'(lo6 - 17'((prod6 + 33'd32768) >> 16));
          arg7  <= arg6;
          wz7   <= wz6;
          // amplitude term
          pa8   <= amp[p] * $signed({1'b0, e7});
          e8    <= e7;
          arg8  <= arg7;
          wz8   <= wz7;
          ae9   <= 34'((pa8 + 50'sd32768) >>> 16);
          e9    <= e8;
          arg9  <= arg8;
          wz9   <= wz8;
          // f = 2 * ae * arg
          g10   <= ae9 * arg9;
          ae10  <= ae9;
          e10   <= e9;
          arg10 <= arg9;
          wz10  <= wz9;
          f11   <= 38'(($signed({g10, 1'b0}) + 54'sd32768) >>> 16);
          ae11  <= ae10;
          e11   <= e10;
          arg11 <= arg10;
          wz11  <= wz10;
          // derivative numerators
          h12   <= f11 * arg11;
          nc12  <= {f11, 16'b0};
          ae12  <= ae11;
          e12   <= e11;
          wz12  <= wz11;
        end
      end

      gsg_div #(.NW(54), .SW(51)) u_dc (
        .clk      (clk),
        .en       (adv),
        .num      (nc12),
        .den      (wid[p]),
        .side_in  ({ae12, e12}),
        .quo      (dcq[p]),
        .side_out ({ae_o[p], e_o[p]})
      );

      gsg_div #(.NW(57), .SW(2)) u_dw (
        .clk      (clk),
        .en       (adv),
        .num      (h12),
        .den      (wid[p]),
        .side_in  ({wz12, e12 == '0}),
        .quo      (dwq[p]),
        .side_out ({wz_o[p], ez_o[p]})
      );
    end else begin : g_off
      assign dcq[p]  = '0;
      assign dwq[p]  = '0;
      assign ae_o[p] = '0;
      assign e_o[p]  = '0;
      assign ez_o[p] = 1'b1;
      assign wz_o[p] = 1'b0;
    end
  end

  // result assembly
  always_comb begin
    flt   = wz_o[0] | wz_o[1];
    msum  = 35'(ae_o[0]) + 35'(ae_o[1]);
    if (msum > 35'sd2147483647) begin
      model = 32'sh7fffffff;
    end else if (msum < -35'sd2147483648) begin
      model = 32'sh80000000;
    end else begin
      model = 32'(msum);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_fault <= flt;
      if (flt) begin
        out_data <= '0;
      end else begin
        out_data <= {ez_o[1] ? 32'b0 : dwq[1], ez_o[1] ? 32'b0 : dcq[1],
                     {15'b0, e_o[1]},
                     ez_o[0] ? 32'b0 : dwq[0], ez_o[0] ? 32'b0 : dcq[0],
                     {15'b0, e_o[0]}, model};
      end
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = out_fault;

endmodule

[rtl/core/gsg_div.sv]
// Pipelined signed divider, one quotient bit per stage, result saturated to
// 32-bit signed, quotient truncated toward zero. Uses gsg_pkg.
`timescale 1ns / 1ps

module gsg_div #(
  parameter int NW = 49,
  parameter int SW = 1
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [NW-1:0]                num,
  input  logic signed [gsg_pkg::QUO_BITS-1:0] den,
  input  logic        [SW-1:0]                side_in,
  output logic signed [gsg_pkg::QUO_BITS-1:0] quo,
  output logic        [SW-1:0]                side_out
);

  localparam int QB = gsg_pkg::QUO_BITS;
  localparam logic [QB-1:0] POS_MAX = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] NEG_MIN = {1'b1, {(QB-1){1'b0}}};

  logic [QB-1:0] dmag;
  logic [NW-1:0] nmag;
  logic          sat0;

  logic [QB-1:0] rem  [QB+1];
  logic [QB-1:0] low  [QB+1];
  logic [QB-1:0] qacc [QB+1];
  logic          neg  [QB+1];
  logic          sat  [QB+1];
  logic [SW-1:0] sd   [QB+1];

  // magnitudes; quotient of 2^32 or more saturates
  assign dmag = den[QB-1] ? QB'(-den) : QB'(den);
  assign nmag = num[NW-1] ? NW'(-num) : NW'(num);
  assign sat0 = NW'(nmag[NW-1:QB]) >= NW'(dmag);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= sat0 ? '0 : QB'(nmag[NW-1:QB]);
      low[0]  <= nmag[QB-1:0];
      qacc[0] <= '0;
      neg[0]  <= num[NW-1] ^ den[QB-1];
      sat[0]  <= sat0;
      sd[0]   <= side_in;
    end
  end

  // restoring steps
  for (genvar s = 1; s <= QB; s++) begin : g_stage
    logic [QB:0] trial;
    logic        ge;
    assign trial = {rem[s-1], low[s-1][QB-1]};
    assign ge    = trial >= {1'b0, dmag};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= ge ? QB'(trial - {1'b0, dmag}) : QB'(trial);
        low[s]  <= {low[s-1][QB-2:0], 1'b0};
        qacc[s] <= {qacc[s-1][QB-2:0], ge};
        neg[s]  <= neg[s-1];
        sat[s]  <= sat[s-1];
        sd[s]   <= sd[s-1];
      end
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= sd[QB];
      if (sat[QB]) begin
        quo <= neg[QB] ? NEG_MIN : POS_MAX;
      end else if (!neg[QB]) begin
        quo <= (qacc[QB] > POS_MAX) ? POS_MAX : qacc[QB];
      end else begin
        quo <= (qacc[QB] > NEG_MIN) ? NEG_MIN : QB'(-qacc[QB]);
      end
    end
  end

endmodule
